[rtl/pressure_temperature_compensation_top_defines.svh]
// Assertion macros shared by the compensation RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PTC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PTC_ASSERT(lbl, prop, msg)
`define PTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/ptc_pkg.sv]
// Shared types, constants and arithmetic helpers for the compensation block.
// No dependencies.
`timescale 1ns / 1ps
package ptc_pkg;
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
	localparam int unsigned DIV_W = 64;

	localparam logic [1:0] REG_TEMP = 2'd0;
	localparam logic [1:0] REG_PA = 2'd1;
	localparam logic [1:0] REG_PB = 2'd2;
	localparam logic [1:0] REG_PC = 2'd3;

	localparam logic [63:0] T_OFFSET = 64'd128000;
	localparam logic [63:0] P_FULL = 64'd1048576;
	localparam logic [63:0] P_SCALE = 64'd3125;
	localparam logic [63:0] P_ROUND = 64'h0000_8000_0000_0000;
	localparam logic [31:0] TC_ROUND = 32'd128;

	typedef struct packed {
		logic [47:0] temp;
		logic [63:0] pa;
		logic [63:0] pb;
		logic [15:0] pc;
	} cal_t;

	typedef struct packed {
		logic [31:0] fine;
		logic [31:0] tc;
		logic [19:0] adc_p;
	} tq_t;

	typedef struct packed {
		logic [31:0] fine;
		logic [31:0] tc;
		logic        dz;
	} side_t;

	// partial products of a 64-bit product taken modulo 2^64
	typedef struct packed {
		logic [63:0] ll;
		logic [31:0] cr;
	} pp_t;

	function automatic pp_t pp64(input logic [63:0] a, input logic [63:0] b);
		pp_t r;
		r.ll = 64'(a[31:0]) * 64'(b[31:0]);
		r.cr = a[31:0] * b[63:32] + a[63:32] * b[31:0];
		return r;
	endfunction

	function automatic logic [63:0] pp_sum(input pp_t p);
		return p.ll + {p.cr, 32'd0};
	endfunction

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
		return 64'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction
endpackage

[rtl/ptc_front.sv]
// Front end: accepts raw samples and works out the temperature terms.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [19:0]         raw_temperature,
	input  logic [19:0]         raw_pressure,
	input  logic [47:0]         temp_cal,
	output logic                q_valid,
	input  logic                q_ready,
	output ptc_pkg::tq_t        q_data
);
	logic [31:0] t1, t2, t3, d1, d2, tc;
	logic        en;
	logic [2:0]  vld_q;
	logic [31:0] pv1_s1, psq_s1, v1_s2, st3_s2, fine_s3;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3;

	assign t1 = {16'd0, temp_cal[15:0]};
	assign t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
	assign t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
	assign d1 = {15'd0, raw_temperature[19:3]} - {t1[30:0], 1'b0};
	assign d2 = {16'd0, raw_temperature[19:4]} - t1;

	assign en = !vld_q[2] || q_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pv1_s1  <= d1 * t2;
			psq_s1  <= d2 * d2;
			adcp_s1 <= raw_pressure;
			v1_s2   <= ptc_pkg::asr32(pv1_s1, 11);
			st3_s2  <= ptc_pkg::asr32(psq_s1, 12) * t3;
			adcp_s2 <= adcp_s1;
			fine_s3 <= v1_s2 + ptc_pkg::asr32(st3_s2, 14);
			adcp_s3 <= adcp_s2;
		end
	end

	// (fine * 5 + 128) / 256, rounded down
	assign tc = ptc_pkg::asr32(fine_s3 + {fine_s3[29:0], 2'b00} + ptc_pkg::TC_ROUND, 8);

	assign q_valid = vld_q[2];
	assign q_data = '{fine: fine_s3, tc: tc, adc_p: adcp_s3};
endmodule

[rtl/ptc_fifo.sv]
// Short queue between the front and back ends.
// Depends on ptc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pressure_temperature_compensation_top_defines.svh"
module ptc_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  ptc_pkg::tq_t wr_data,
	input  logic         pop,
	output ptc_pkg::tq_t rd_data,
	output logic         full,
	output logic         empty
);
	ptc_pkg::tq_t                     mem_q [ptc_pkg::QDEPTH];
	logic [ptc_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [ptc_pkg::QCNT_W-1:0]       cnt_q;

	assign full = (cnt_q == ptc_pkg::QCNT_W'(ptc_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [ptc_pkg::QPTR_W-1:0] nxt(input logic [ptc_pkg::QPTR_W-1:0] p);
		return (p == ptc_pkg::QPTR_W'(ptc_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= nxt(wr_ptr_q);
			if (pop) rd_ptr_q <= nxt(rd_ptr_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	`PTC_ASSERT(a_cnt_bound, cnt_q <= ptc_pkg::QCNT_W'(ptc_pkg::QDEPTH), "queue count overrun")
	`PTC_ASSERT(a_no_push_full, full |-> !push, "push into full queue")
	`PTC_ASSERT(a_no_pop_empty, empty |-> !pop, "pop from empty queue")
	`PTC_ASSERT(a_pop_dec, (pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1), "count did not drop")
endmodule

[rtl/ptc_div.sv]
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating to zero.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [63:0]    num,
	input  logic [63:0]    den,
	input  ptc_pkg::side_t side_in,
	output logic           out_valid,
	output logic [63:0]    quo,
	output ptc_pkg::side_t side_out
);
	localparam int unsigned N = ptc_pkg::DIV_W;

	logic [N-1:0]   rem_q [N+1];
	logic [N-1:0]   quo_q [N+1];
	logic [N-1:0]   dvs_q [N+1];
	logic           neg_q [N+1];
	ptc_pkg::side_t side_q [N+1];
	logic [N+1:0]   vld_q;
	logic [N-1:0]   res_q;
	ptc_pkg::side_t res_side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N:0], in_valid};
		end
	end

	// take magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= '0;
			quo_q[0]  <= num[N-1] ? (N'(0) - num) : num;
			dvs_q[0]  <= den[N-1] ? (N'(0) - den) : den;
			neg_q[0]  <= num[N-1] ^ den[N-1];
			side_q[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [N:0] trial;
		logic       ge;
		assign trial = {rem_q[k-1], quo_q[k-1][N-1]};
		assign ge = (trial >= {1'b0, dvs_q[k-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? N'(trial - {1'b0, dvs_q[k-1]}) : trial[N-1:0];
				quo_q[k]  <= {quo_q[k-1][N-2:0], ge};
				dvs_q[k]  <= dvs_q[k-1];
				neg_q[k]  <= neg_q[k-1];
				side_q[k] <= side_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q      <= neg_q[N] ? (N'(0) - quo_q[N]) : quo_q[N];
			res_side_q <= side_q[N];
		end
	end

	assign out_valid = vld_q[N+1];
	assign quo = res_q;
	assign side_out = res_side_q;
endmodule

[rtl/ptc_back.sv]
// Back end: pressure polynomial, division and correction terms, output register.
// Depends on ptc_pkg and ptc_div.
`timescale 1ns / 1ps
module ptc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ptc_pkg::cal_t cal,
	input  logic          in_valid,
	output logic          in_ready,
	input  ptc_pkg::tq_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   fine_temperature,
	output logic [31:0]   temperature_centi,
	output logic [31:0]   pressure_q24_8,
	output logic          divide_by_zero
);
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic        en, div_valid;
	logic [8:0]  vpre_q;
	logic [5:0]  vpost_q;
	logic [63:0] div_quo;
	ptc_pkg::side_t div_side_in;
	ptc_pkg::side_t div_side, side_s10, side_s11, side_s12, side_s13, side_s14;
	logic [31:0] fine_s [1:9];
	logic [31:0] tc_s [1:9];

	logic [63:0] a_s1, t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;
	ptc_pkg::pp_t aa_pp_s2, ap5_pp_s2, ap2_pp_s2;
	logic [63:0] aa_s3, ap5_s3, ap2_s3, ap5_s4, ap2_s4, ap5_s5, ap2_s5;
	ptc_pkg::pp_t aap6_pp_s4, aap3_pp_s4;
	logic [63:0] aap6_s5, aap3_s5, b_s6, a2x_s6, n_s7, a1_s8, den_s9, num_s9;
	ptc_pkg::pp_t a1_pp_s7, np_pp_s8;
	logic [63:0] q_s10, ps_s10, q_s11, q_s12, q_s13, q_s14, pss_s12, c2_s12, c2_s13, c2_s14;
	logic [63:0] c1_s14, sum_t;
	ptc_pkg::pp_t pss_pp_s11, c2_pp_s11, c1_pp_s13;
	logic [31:0] press_s15, fine_s15, tc_s15;
	logic        dz_s15;

	assign p1 = {48'd0, cal.pa[15:0]};
	assign p2 = ptc_pkg::sx16(cal.pa[31:16]);
	assign p3 = ptc_pkg::sx16(cal.pa[47:32]);
	assign p4 = ptc_pkg::sx16(cal.pa[63:48]);
	assign p5 = ptc_pkg::sx16(cal.pb[15:0]);
	assign p6 = ptc_pkg::sx16(cal.pb[31:16]);
	assign p7 = ptc_pkg::sx16(cal.pb[47:32]);
	assign p8 = ptc_pkg::sx16(cal.pb[63:48]);
	assign p9 = ptc_pkg::sx16(cal.pc);

	assign en = !vpost_q[5] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpre_q  <= '0;
			vpost_q <= '0;
		end else if (en) begin
			vpre_q  <= {vpre_q[7:0], in_valid};
			vpost_q <= {vpost_q[4:0], div_valid};
		end
	end

	// polynomial in the temperature offset, then numerator and divisor
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= {{32{in_data.fine[31]}}, in_data.fine} - ptc_pkg::T_OFFSET;
			t_s1 <= (ptc_pkg::P_FULL - {44'd0, in_data.adc_p}) << 31;
			fine_s[1] <= in_data.fine;
			tc_s[1] <= in_data.tc;
			for (int i = 2; i <= 9; i++) begin
				fine_s[i] <= fine_s[i-1];
				tc_s[i] <= tc_s[i-1];
			end

			aa_pp_s2  <= ptc_pkg::pp64(a_s1, a_s1);
			ap5_pp_s2 <= ptc_pkg::pp64(a_s1, p5);
			ap2_pp_s2 <= ptc_pkg::pp64(a_s1, p2);
			t_s2      <= t_s1;

			aa_s3  <= ptc_pkg::pp_sum(aa_pp_s2);
			ap5_s3 <= ptc_pkg::pp_sum(ap5_pp_s2);
			ap2_s3 <= ptc_pkg::pp_sum(ap2_pp_s2);
			t_s3   <= t_s2;

			aap6_pp_s4 <= ptc_pkg::pp64(aa_s3, p6);
			aap3_pp_s4 <= ptc_pkg::pp64(aa_s3, p3);
			ap5_s4 <= ap5_s3;
			ap2_s4 <= ap2_s3;
			t_s4   <= t_s3;

			aap6_s5 <= ptc_pkg::pp_sum(aap6_pp_s4);
			aap3_s5 <= ptc_pkg::pp_sum(aap3_pp_s4);
			ap5_s5  <= ap5_s4;
			ap2_s5  <= ap2_s4;
			t_s5    <= t_s4;

			b_s6   <= aap6_s5 + (ap5_s5 << 17) + (p4 << 35);
			a2x_s6 <= ptc_pkg::asr64(aap3_s5, 8) + (ap2_s5 << 12) + ptc_pkg::P_ROUND;
			t_s6   <= t_s5;

			n_s7     <= t_s6 - b_s6;
			a1_pp_s7 <= ptc_pkg::pp64(a2x_s6, p1);

			a1_s8    <= ptc_pkg::pp_sum(a1_pp_s7);
			np_pp_s8 <= ptc_pkg::pp64(n_s7, ptc_pkg::P_SCALE);

			den_s9 <= ptc_pkg::asr64(a1_s8, 33);
			num_s9 <= ptc_pkg::pp_sum(np_pp_s8);
		end
	end

	assign div_side_in = '{fine: fine_s[9], tc: tc_s[9], dz: (den_s9 == '0)};

	ptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vpre_q[8]),
		.num      (num_s9),
		.den      (den_s9),
		.side_in  (div_side_in),
		.out_valid(div_valid),
		.quo      (div_quo),
		.side_out (div_side)
	);

	assign sum_t = q_s14 + ptc_pkg::asr64(c1_s14, 25) + ptc_pkg::asr64(c2_s14, 19);

	// second-order correction on the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			q_s10    <= div_quo;
			ps_s10   <= ptc_pkg::asr64(div_quo, 13);
			side_s10 <= div_side;

			pss_pp_s11 <= ptc_pkg::pp64(ps_s10, ps_s10);
			c2_pp_s11  <= ptc_pkg::pp64(p8, q_s10);
			q_s11      <= q_s10;
			side_s11   <= side_s10;

			pss_s12  <= ptc_pkg::pp_sum(pss_pp_s11);
			c2_s12   <= ptc_pkg::pp_sum(c2_pp_s11);
			q_s12    <= q_s11;
			side_s12 <= side_s11;

			c1_pp_s13 <= ptc_pkg::pp64(p9, pss_s12);
			c2_s13    <= c2_s12;
			q_s13     <= q_s12;
			side_s13  <= side_s12;

			c1_s14   <= ptc_pkg::pp_sum(c1_pp_s13);
			c2_s14   <= c2_s13;
			q_s14    <= q_s13;
			side_s14 <= side_s13;

			press_s15 <= side_s14.dz ? '0 : 32'(ptc_pkg::asr64(sum_t, 8) + (p7 << 4));
			dz_s15    <= side_s14.dz;
			fine_s15  <= side_s14.fine;
			tc_s15    <= side_s14.tc;
		end
	end

	assign out_valid = vpost_q[5];
	assign fine_temperature = fine_s15;
	assign temperature_centi = tc_s15;
	assign pressure_q24_8 = press_s15;
	assign divide_by_zero = dz_s15;
endmodule

[rtl/pressure_temperature_compensation_top.sv]
// Top level of the barometer compensation block: calibration registers and
// the front end, queue and back end. Depends on ptc_pkg, ptc_front, ptc_fifo, ptc_back.
`timescale 1ns / 1ps
// Usage:
//   Input channel: in_valid/in_ready carry one item of raw_temperature and
//   raw_pressure. Output channel: out_valid/out_ready carry one item of
//   fine_temperature, temperature_centi, pressure_q24_8 and divide_by_zero.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   write only while the block holds no item in flight.
//   Throughput: one item per cycle while the output does not stall. Every unit
//   is fully pipelined; the divider in the back end, with 64 stages of one
//   quotient bit each, sets the depth.
//   An accepted item passes through the front end, the queue and the back
//   end to out_valid.
//   Reset: arst_n clears all calibration registers, valid bits and the queue.
//   Stall: when out_valid is high and out_ready low the back end holds; the
//   two-entry queue absorbs the front end's items, then in_ready drops.
module pressure_temperature_compensation_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] fine_temperature,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]        pressure_q24_8,
	output logic               divide_by_zero,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	ptc_pkg::cal_t cal_q;
	ptc_pkg::tq_t  fr_data, q_data;
	logic          fr_valid, q_full, q_empty, push, pop, bk_ready;
	logic [31:0]   fine_w, tc_w;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptc_pkg::REG_TEMP: cal_q.temp <= cfg_data[47:0];
				ptc_pkg::REG_PA:   cal_q.pa <= cfg_data;
				ptc_pkg::REG_PB:   cal_q.pb <= cfg_data;
				ptc_pkg::REG_PC:   cal_q.pc <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// front end: temperature terms
	ptc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_temperature(raw_temperature),
		.raw_pressure   (raw_pressure),
		.temp_cal       (cal_q.temp),
		.q_valid        (fr_valid),
		.q_ready        (!q_full),
		.q_data         (fr_data)
	);

	// push when the queue has room; pop when the back end advances
	assign push = fr_valid && !q_full;
	assign pop = bk_ready && !q_empty;

	ptc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(fr_data),
		.pop    (pop),
		.rd_data(q_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back end: pressure and output register
	ptc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cal              (cal_q),
		.in_valid         (!q_empty),
		.in_ready         (bk_ready),
		.in_data          (q_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.fine_temperature (fine_w),
		.temperature_centi(tc_w),
		.pressure_q24_8   (pressure_q24_8),
		.divide_by_zero   (divide_by_zero)
	);

	assign fine_temperature = fine_w;
	assign temperature_centi = tc_w;
endmodule

[tb/ptc_checker.sv]
// Scoreboard for the compensation block: tracks the calibration writes,
// predicts each result from the accepted items and compares. Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] fine_temperature,
	input  logic [31:0] temperature_centi,
	input  logic [31:0] pressure_q24_8,
	input  logic        divide_by_zero,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          mismatches,
	output int          in_flight
);
	typedef struct packed {
		logic [31:0] fine;
		logic [31:0] centi;
		logic [31:0] press;
		logic        dz;
	} comp_t;

	logic [47:0] cal_tw;
	logic [63:0] cal_a, cal_b;
	logic [15:0] cal_c;
	comp_t       pending_q[$];
	int          errs;

	function automatic logic [63:0] ext16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] quot_trunc(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] mn, md, q;
		mn = n[63] ? -n : n;
		md = d[63] ? -d : d;
		q = mn / md;
		return (n[63] != d[63]) ? -q : q;
	endfunction

	function automatic comp_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
		logic [31:0] t1, t2, t3, d1, v1, d2, sq, v2, fine, prod;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] a, b, den, num, p, ps, c1, c2;
		comp_t r;
		t1 = {16'd0, cal_tw[15:0]};
		t2 = {{16{cal_tw[31]}}, cal_tw[31:16]};
		t3 = {{16{cal_tw[47]}}, cal_tw[47:32]};
		d1 = {12'd0, adc_t} >> 3;
		d1 = d1 - (t1 << 1);
		prod = d1 * t2;
		v1 = $signed(prod) >>> 11;
		d2 = ({12'd0, adc_t} >> 4) - t1;
		prod = d2 * d2;
		sq = $signed(prod) >>> 12;
		prod = sq * t3;
		v2 = $signed(prod) >>> 14;
		fine = v1 + v2;
		prod = fine * 32'd5 + 32'd128;
		r.fine = fine;
		r.centi = $signed(prod) >>> 8;
		p1 = {48'd0, cal_a[15:0]};
		p2 = ext16(cal_a[31:16]);
		p3 = ext16(cal_a[47:32]);
		p4 = ext16(cal_a[63:48]);
		p5 = ext16(cal_b[15:0]);
		p6 = ext16(cal_b[31:16]);
		p7 = ext16(cal_b[47:32]);
		p8 = ext16(cal_b[63:48]);
		p9 = ext16(cal_c);
		a = {{32{fine[31]}}, fine} - 64'd128000;
		b = a * a * p6;
		b = b + ((a * p5) << 17);
		b = b + (p4 << 35);
		den = a * a * p3;
		den = $signed(den) >>> 8;
		den = den + ((a * p2) << 12);
		den = ((64'd1 << 47) + den) * p1;
		den = $signed(den) >>> 33;
		r.press = '0;
		r.dz = (den == 64'd0);
		if (!r.dz) begin
			p = 64'd1048576 - {44'd0, adc_p};
			num = ((p << 31) - b) * 64'd3125;
			p = quot_trunc(num, den);
			ps = $signed(p) >>> 13;
			c1 = p9 * ps * ps;
			c1 = $signed(c1) >>> 25;
			c2 = p8 * p;
			c2 = $signed(c2) >>> 19;
			num = p + c1 + c2;
			num = $signed(num) >>> 8;
			p = num + (p7 << 4);
			r.press = p[31:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		comp_t want;
		if (!arst_n) begin
			cal_tw = '0;
			cal_a = '0;
			cal_b = '0;
			cal_c = '0;
			pending_q.delete();
			errs = 0;
		end else begin
			if (in_valid && in_ready)
				pending_q.push_back(compensate(raw_temperature, raw_pressure));
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					errs++;
					$error("result with nothing expected");
				end else begin
					want = pending_q.pop_front();
					if (fine_temperature !== want.fine) begin
						errs++;
						$error("fine_temperature: expected %0d, got %0d",
							$signed(want.fine), $signed(fine_temperature));
					end
					if (temperature_centi !== want.centi) begin
						errs++;
						$error("temperature_centi: expected %0d, got %0d",
							$signed(want.centi), $signed(temperature_centi));
					end
					if (pressure_q24_8 !== want.press) begin
						errs++;
						$error("pressure_q24_8: expected %h, got %h",
							want.press, pressure_q24_8);
					end
					if (divide_by_zero !== want.dz) begin
						errs++;
						$error("divide_by_zero: expected %b, got %b",
							want.dz, divide_by_zero);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					ptc_pkg::REG_TEMP: cal_tw = cfg_data[47:0];
					ptc_pkg::REG_PA:   cal_a = cfg_data;
					ptc_pkg::REG_PB:   cal_b = cfg_data;
					ptc_pkg::REG_PC:   cal_c = cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	assign mismatches = errs;
	assign in_flight = pending_q.size();
endmodule

[tb/tb_pressure_temperature_compensation_top.sv]
// Testbench top for the compensation block: clock, reset, calibration phases,
// bursty item traffic and the verdict. Depends on ptc_pkg, ptc_checker and pressure_temperature_compensation_top.
`timescale 1ns / 1ps
module tb_pressure_temperature_compensation_top;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [19:0] raw_temperature = '0;
	logic [19:0] raw_pressure = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] fine_temperature, temperature_centi, pressure_q24_8;
	logic        divide_by_zero;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = ptc_pkg::REG_TEMP;
	logic [63:0] cfg_data = '0;
	int          mismatches, in_flight;
	int          cycles = 0;

	always #10 clk = ~clk;

	pressure_temperature_compensation_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.out_valid(out_valid), .out_ready(out_ready),
		.fine_temperature(fine_temperature), .temperature_centi(temperature_centi),
		.pressure_q24_8(pressure_q24_8), .divide_by_zero(divide_by_zero),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ptc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.out_valid(out_valid), .out_ready(out_ready),
		.fine_temperature(fine_temperature), .temperature_centi(temperature_centi),
		.pressure_q24_8(pressure_q24_8), .divide_by_zero(divide_by_zero),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .in_flight(in_flight)
	);

	// Abort on a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: alternate free-running stretches with stretches of random stalls.
	int stall_len = 0;
	logic stall_mode = 1'b0;
	always @(posedge clk) begin
		if (stall_len == 0) begin
			stall_mode = $urandom_range(0, 2) != 0;
			stall_len = $urandom_range(5, 60);
		end else begin
			stall_len--;
		end
		out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	int burst_left = 0;

	// Present one item, after a random idle gap at some burst starts, and hold it until the block takes it.
	task automatic send_item(input logic [19:0] t, input logic [19:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		raw_temperature <= t;
		raw_pressure <= p;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Drop valid, wait for every item to come back, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cal(input logic [1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [63:0] t, input logic [63:0] a,
			input logic [63:0] b, input logic [63:0] c);
		write_cal(ptc_pkg::REG_TEMP, t);
		write_cal(ptc_pkg::REG_PA, a);
		write_cal(ptc_pkg::REG_PB, b);
		write_cal(ptc_pkg::REG_PC, c);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [19:0] rand_raw();
		case ($urandom_range(0, 5))
			0: return 20'h0;
			1: return 20'hFFFFF;
			default: return 20'($urandom());
		endcase
	endfunction

	// Typical factory calibration, with a little random spread when jitter is set.
	task automatic write_typical(input bit jitter);
		logic [15:0] w[12];
		w = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
			16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
		if (jitter)
			foreach (w[i]) w[i] = w[i] + 16'($urandom_range(0, 64)) - 16'd32;
		write_all({16'd0, w[2], w[1], w[0]}, {w[6], w[5], w[4], w[3]},
			{w[10], w[9], w[8], w[7]}, {48'd0, w[11]});
	endtask

	initial begin
		logic [19:0] edge_vals[4];
		int phase;
		edge_vals = '{20'h00000, 20'hFFFFF, 20'h55555, 20'hAAAAA};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero calibration after reset: divisor is zero, so the flag must rise.
		foreach (edge_vals[i]) send_item(edge_vals[i], edge_vals[3 - i]);
		drain();

		// Typical calibration over the raw extremes and alternating patterns.
		write_typical(1'b0);
		foreach (edge_vals[i])
			foreach (edge_vals[j]) send_item(edge_vals[i], edge_vals[j]);
		drain();

		// All-ones words: every signed coefficient is -1, P1 is at its top.
		write_all({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
		send_item(20'hFFFFF, 20'h00000);
		send_item(20'h00000, 20'hFFFFF);
		send_item(20'h80000, 20'h80000);
		drain();

		// Random phases: half realistic calibration, the rest random or extreme words.
		for (phase = 0; phase < 16; phase++) begin
			case (phase % 4)
				0, 1: write_typical(1'b1);
				2: write_all(rand64(), rand64(), rand64(), rand64());
				default: write_all({16'd0, 16'h8000, 16'h7FFF, 16'($urandom())},
					{16'h7FFF, 16'h8000, 16'($urandom()), 16'hFFFF},
					{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 64'($urandom()));
			endcase
			repeat (40) send_item(rand_raw(), rand_raw());
			drain();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
